// ===== rtl/core/e2f_pkg.sv =====
// Shared types, constants and helper functions for the equirectangular to
// fisheye coordinate unit. No dependencies.
package e2f_pkg;

    localparam int GRID_SIZE_DEF = 512;

    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int FOCAL_W = 12;
    localparam int SPAN_W  = 13;
    localparam int OUT_W   = 18;

    localparam int ANG_W    = 32;
    localparam int CW       = 34;
    localparam int VAL_W    = 32;
    localparam int CORDIC_N = 24;

    localparam int DIV_Q_W = 30;
    localparam int DEN_W   = SPAN_W + 14;
    localparam int NUM_W   = 44;

    localparam logic signed [CW-1:0]    GAIN_INV = 34'sd652032874;
    localparam logic signed [VAL_W-1:0] Q30_ONE  = 32'sd1073741824;

    localparam logic [FOCAL_W-1:0] FOCAL_RST = 12'd900;
    localparam logic [SPAN_W-1:0]  SPAN_RST  = 13'd2880;

    localparam logic signed [33:0] HALF_Q16 = 34'sd32768;
    localparam logic signed [33:0] OUT_MAX  = 34'sd131071;
    localparam logic signed [33:0] OUT_MIN  = -34'sd131072;

    localparam logic [ANG_W-1:0] ATAN_BAM [CORDIC_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef enum logic {
        CFG_FOCAL = 1'b0,
        CFG_SPAN  = 1'b1
    } cfg_index_t;

    // quadrant fix-up carried alongside a rotation chain
    typedef struct packed {
        logic       exact;
        logic [1:0] quad;
        logic       neg;
    } rot_fix_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        rot_fix_t             fix;
    } rot_pre_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] co;
        logic signed [VAL_W-1:0] si;
    } sincos_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     z;
    } vec_pre_t;

    // fold the angle into the right half plane before rotation
    function automatic rot_pre_t rot_pre(input logic [ANG_W-1:0] a);
        rot_pre_t         r;
        logic [ANG_W-1:0] a2;
        r.fix.quad  = a[ANG_W-1:ANG_W-2];
        r.fix.exact = (a[ANG_W-3:0] == '0);
        r.fix.neg   = (a[ANG_W-1:ANG_W-2] == 2'd1) || (a[ANG_W-1:ANG_W-2] == 2'd2);
        a2          = {a[ANG_W-1] ^ r.fix.neg, a[ANG_W-2:0]};
        r.z         = CW'($signed(a2));
        r.x         = GAIN_INV;
        r.y         = '0;
        return r;
    endfunction

    // undo the fold, or give exact values on quarter turns
    function automatic sincos_t rot_post(input rot_fix_t f, input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
        sincos_t              r;
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        nx = f.neg ? -x : x;
        ny = f.neg ? -y : y;
        if (f.exact) begin
            unique case (f.quad)
                2'd0: begin r.co = Q30_ONE;  r.si = '0;       end
                2'd1: begin r.co = '0;       r.si = Q30_ONE;  end
                2'd2: begin r.co = -Q30_ONE; r.si = '0;       end
                default: begin r.co = '0;    r.si = -Q30_ONE; end
            endcase
        end else begin
            r.co = $signed(nx[VAL_W-1:0]);
            r.si = $signed(ny[VAL_W-1:0]);
        end
        return r;
    endfunction

    // move the vector into the right half plane before vectoring
    function automatic vec_pre_t vec_pre(input logic signed [VAL_W-1:0] x,
                                         input logic signed [VAL_W-1:0] y);
        vec_pre_t r;
        if (x < 0) begin
            r.x = -CW'(x);
            r.y = -CW'(y);
            r.z = 32'h80000000;
        end else begin
            r.x = CW'(x);
            r.y = CW'(y);
            r.z = '0;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [33:0] v);
        logic signed [33:0] c;
        if (v > OUT_MAX) begin
            c = OUT_MAX;
        end else if (v < OUT_MIN) begin
            c = OUT_MIN;
        end else begin
            c = v;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/e2f_rot_cell.sv =====
// One CORDIC rotation-mode iteration with a side channel.
// Depends on e2f_pkg.
module e2f_rot_cell #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [e2f_pkg::CW-1:0]  in_x,
    input  logic signed [e2f_pkg::CW-1:0]  in_y,
    input  logic signed [e2f_pkg::CW-1:0]  in_z,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic signed [e2f_pkg::CW-1:0]  out_x,
    output logic signed [e2f_pkg::CW-1:0]  out_y,
    output logic signed [e2f_pkg::CW-1:0]  out_z,
    output logic [SIDE_W-1:0]              out_side
);
    logic                          valid_reg;
    logic signed [e2f_pkg::CW-1:0] x_reg, x_next;
    logic signed [e2f_pkg::CW-1:0] y_reg, y_next;
    logic signed [e2f_pkg::CW-1:0] z_reg, z_next;
    logic [SIDE_W-1:0]             side_reg;
    logic signed [e2f_pkg::CW-1:0] dx, dy, da;

    always_comb begin
        dx = in_y >>> SHIFT;
        dy = in_x >>> SHIFT;
        da = $signed(e2f_pkg::CW'(e2f_pkg::ATAN_BAM[SHIFT]));
        if (!in_z[e2f_pkg::CW-1]) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - da;
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + da;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;
endmodule

// ===== rtl/core/e2f_vec_cell.sv =====
// One CORDIC vectoring-mode iteration with a side channel.
// Depends on e2f_pkg.
module e2f_vec_cell #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [e2f_pkg::CW-1:0]   in_x,
    input  logic signed [e2f_pkg::CW-1:0]   in_y,
    input  logic [e2f_pkg::ANG_W-1:0]       in_z,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic signed [e2f_pkg::CW-1:0]   out_x,
    output logic signed [e2f_pkg::CW-1:0]   out_y,
    output logic [e2f_pkg::ANG_W-1:0]       out_z,
    output logic [SIDE_W-1:0]               out_side
);
    logic                          valid_reg;
    logic signed [e2f_pkg::CW-1:0] x_reg, x_next;
    logic signed [e2f_pkg::CW-1:0] y_reg, y_next;
    logic [e2f_pkg::ANG_W-1:0]     z_reg, z_next;
    logic [SIDE_W-1:0]             side_reg;
    logic signed [e2f_pkg::CW-1:0] dx, dy;

    always_comb begin
        dx = in_y >>> SHIFT;
        dy = in_x >>> SHIFT;
        if (in_y[e2f_pkg::CW-1]) begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - e2f_pkg::ATAN_BAM[SHIFT];
        end else begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + e2f_pkg::ATAN_BAM[SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;
endmodule

// ===== rtl/core/e2f_div_cell.sv =====
// One restoring-division step: brings down one dividend bit, forms one quotient bit.
// Depends on e2f_pkg.
module e2f_div_cell #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic [e2f_pkg::DEN_W-1:0]       den,
    input  logic                            in_valid,
    input  logic [e2f_pkg::DEN_W-1:0]       in_rem,
    input  logic [e2f_pkg::DIV_Q_W-1:0]     in_quo,
    input  logic [e2f_pkg::DIV_Q_W-1:0]     in_num,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic [e2f_pkg::DEN_W-1:0]       out_rem,
    output logic [e2f_pkg::DIV_Q_W-1:0]     out_quo,
    output logic [e2f_pkg::DIV_Q_W-1:0]     out_num,
    output logic [SIDE_W-1:0]               out_side
);
    logic                          valid_reg;
    logic [e2f_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [e2f_pkg::DIV_Q_W-1:0]   quo_reg, quo_next;
    logic [e2f_pkg::DIV_Q_W-1:0]   num_reg;
    logic [SIDE_W-1:0]             side_reg;
    logic [e2f_pkg::DEN_W:0]       r2;
    logic                          ge;

    always_comb begin
        r2       = {in_rem, in_num[BIT]};
        ge       = (r2 >= {1'b0, den});
        rem_next = ge ? e2f_pkg::DEN_W'(r2 - {1'b0, den}) : e2f_pkg::DEN_W'(r2);
        quo_next = {in_quo[e2f_pkg::DIV_Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            num_reg  <= in_num;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_num   = num_reg;
    assign out_side  = side_reg;
endmodule

// ===== rtl/core/equirect_to_fisheye_coord_unit.sv =====
// Equirectangular pixel to equisolid fisheye coordinate unit; uses e2f_pkg and the
// e2f_rot_cell, e2f_vec_cell and e2f_div_cell chains.
// Throughput one transaction per cycle while the result is not stalled, set by the
// fully pipelined chains of CORDIC and divider cells.
// A stalled result holds the whole pipeline. Reset (aresetn low, synchronous) clears
// every valid bit and loads focal_length = 900, image_span = 2880.
module equirect_to_fisheye_coord_unit #(
    parameter int GRID_SIZE = e2f_pkg::GRID_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input: column [8:0], row [17:9], zero pad [23:18]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // result: coord_x [17:0], coord_y [35:18], coord_y_mirrored [53:36], pad [55:54]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // result flags: no_direction [0]
    output logic [0:0]  m_tuser,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int N   = e2f_pkg::CORDIC_N;
    localparam int NQ  = e2f_pkg::DIV_Q_W;
    localparam int CW  = e2f_pkg::CW;
    localparam int VW  = e2f_pkg::VAL_W;
    localparam int AW  = e2f_pkg::ANG_W;

    // Angle = floor(idx * 2^32 / GRID_SIZE) built as idx*A + floor(idx*B / GRID_SIZE),
    // with 2^32 = A*GRID_SIZE + B and the small quotient taken by an exact reciprocal.
    localparam logic [63:0] A_C  = 64'h1_0000_0000 / 64'(GRID_SIZE);
    localparam logic [63:0] B_C  = 64'h1_0000_0000 % 64'(GRID_SIZE);
    localparam int          B_W  = $clog2(GRID_SIZE);
    localparam int          T_W  = e2f_pkg::COL_W + B_W;
    localparam int          K    = T_W + B_W;
    localparam logic [63:0] M_C  = ((64'd1 << K) + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE);
    localparam int          U_W  = T_W + K - 1;
    localparam int          CA_W = e2f_pkg::COL_W + 31;
    localparam int          Q_W  = CA_W + 1;

    // Pipeline advance: every stage moves when the output register is free or taken.
    logic adv;

    // ---------------- configuration ----------------
    logic [e2f_pkg::FOCAL_W-1:0] focal_reg;
    logic [e2f_pkg::SPAN_W-1:0]  span_reg;
    logic [e2f_pkg::SPAN_W-1:0]  span_eff;
    logic [e2f_pkg::DEN_W-1:0]   den;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= e2f_pkg::FOCAL_RST;
            span_reg  <= e2f_pkg::SPAN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (e2f_pkg::cfg_index_t'(cfg_index))
                e2f_pkg::CFG_FOCAL: focal_reg <= cfg_data[e2f_pkg::FOCAL_W-1:0];
                e2f_pkg::CFG_SPAN:  span_reg  <= cfg_data;
                default:            focal_reg <= focal_reg;
            endcase
        end
    end

    // a zero span divides as one
    assign span_eff = (span_reg == '0) ? e2f_pkg::SPAN_W'(1) : span_reg;
    assign den      = {span_eff, 14'd0};

    // ---------------- angle generation (3 stages) ----------------
    logic [e2f_pkg::COL_W-1:0] s_col;
    logic [e2f_pkg::ROW_W-1:0] s_row;
    assign s_col = s_tdata[8:0];
    assign s_row = s_tdata[17:9];

    logic            a1_valid_reg, a2_valid_reg, a3_valid_reg;
    logic [T_W-1:0]  a1_tc_reg, a1_tr_reg;
    logic [CA_W-1:0] a1_cc_reg, a1_cr_reg, a2_cc_reg, a2_cr_reg;
    logic [U_W-1:0]  a2_uc_reg, a2_ur_reg;
    logic [AW-1:0]   a3_yaw_reg, a3_pitch_reg;
    logic [Q_W-1:0]  qc_next, qr_next;

    always_comb begin
        qc_next = Q_W'(a2_cc_reg) + Q_W'(a2_uc_reg >> K);
        qr_next = Q_W'(a2_cr_reg) + Q_W'(a2_ur_reg >> K);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
            a3_valid_reg <= 1'b0;
        end else if (adv) begin
            a1_valid_reg <= s_tvalid;
            a2_valid_reg <= a1_valid_reg;
            a3_valid_reg <= a2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_tc_reg    <= T_W'(s_col) * T_W'(B_C);
            a1_tr_reg    <= T_W'(s_row) * T_W'(B_C);
            a1_cc_reg    <= CA_W'(s_col) * CA_W'(A_C);
            a1_cr_reg    <= CA_W'(s_row) * CA_W'(A_C);
            a2_uc_reg    <= U_W'(a1_tc_reg) * U_W'(M_C);
            a2_ur_reg    <= U_W'(a1_tr_reg) * U_W'(M_C);
            a2_cc_reg    <= a1_cc_reg;
            a2_cr_reg    <= a1_cr_reg;
            // yaw starts at -pi, pitch at -pi/2 (half the row step)
            a3_yaw_reg   <= 32'h80000000 + qc_next[AW-1:0];
            a3_pitch_reg <= 32'hC0000000 + qr_next[AW:1];
        end
    end

    // ---------------- rotation chains for yaw and pitch ----------------
    e2f_pkg::rot_pre_t r1_pre, r2_pre;
    assign r1_pre = e2f_pkg::rot_pre(a3_yaw_reg);
    assign r2_pre = e2f_pkg::rot_pre(a3_pitch_reg);

    logic signed [CW-1:0] r1_x [0:N], r1_y [0:N], r1_z [0:N];
    logic signed [CW-1:0] r2_x [0:N], r2_y [0:N], r2_z [0:N];
    logic                 r1_v [0:N], r2_v [0:N];
    logic [3:0]           r1_s [0:N], r2_s [0:N];

    assign r1_x[0] = r1_pre.x;
    assign r1_y[0] = r1_pre.y;
    assign r1_z[0] = r1_pre.z;
    assign r1_s[0] = r1_pre.fix;
    assign r1_v[0] = a3_valid_reg;
    assign r2_x[0] = r2_pre.x;
    assign r2_y[0] = r2_pre.y;
    assign r2_z[0] = r2_pre.z;
    assign r2_s[0] = r2_pre.fix;
    assign r2_v[0] = a3_valid_reg;

    for (genvar i = 0; i < N; i++) begin : g_r12
        e2f_rot_cell #(.SHIFT(i), .SIDE_W(4)) u_r1 (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(r1_v[i]), .in_x(r1_x[i]), .in_y(r1_y[i]), .in_z(r1_z[i]),
            .in_side(r1_s[i]),
            .out_valid(r1_v[i+1]), .out_x(r1_x[i+1]), .out_y(r1_y[i+1]),
            .out_z(r1_z[i+1]), .out_side(r1_s[i+1])
        );
        e2f_rot_cell #(.SHIFT(i), .SIDE_W(4)) u_r2 (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(r2_v[i]), .in_x(r2_x[i]), .in_y(r2_y[i]), .in_z(r2_z[i]),
            .in_side(r2_s[i]),
            .out_valid(r2_v[i+1]), .out_x(r2_x[i+1]), .out_y(r2_y[i+1]),
            .out_z(r2_z[i+1]), .out_side(r2_s[i+1])
        );
    end

    // ---------------- direction vector ----------------
    e2f_pkg::sincos_t   sc_yaw, sc_pitch;
    logic signed [63:0] p_xx, p_yy;
    logic signed [VW-1:0] m1_x_next;

    assign sc_yaw   = e2f_pkg::rot_post(e2f_pkg::rot_fix_t'(r1_s[N]), r1_x[N], r1_y[N]);
    assign sc_pitch = e2f_pkg::rot_post(e2f_pkg::rot_fix_t'(r2_s[N]), r2_x[N], r2_y[N]);
    assign p_xx     = sc_yaw.co * sc_pitch.co;
    assign p_yy     = sc_yaw.si * sc_pitch.co;
    assign m1_x_next = $signed(p_xx[VW+29:30]);

    logic                 m1_valid_reg, m1_nodir_reg;
    logic signed [VW-1:0] m1_x_reg, m1_y_reg, m1_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (adv) begin
            m1_valid_reg <= r1_v[N] && r2_v[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_x_reg     <= m1_x_next;
            m1_y_reg     <= $signed(p_yy[VW+29:30]);
            m1_z_reg     <= sc_pitch.si;
            // x and z both zero (pointing along the y axis): no horizontal direction
            m1_nodir_reg <= (m1_x_next == '0) && (sc_pitch.si == '0);
        end
    end

    // ---------------- vectoring of (x, z): phi and |xz| ----------------
    e2f_pkg::vec_pre_t v1_pre;
    assign v1_pre = e2f_pkg::vec_pre(m1_x_reg, m1_z_reg);

    logic signed [CW-1:0] v1_x [0:N], v1_y [0:N];
    logic [AW-1:0]        v1_z [0:N];
    logic                 v1_v [0:N];
    logic [VW:0]          v1_s [0:N];

    assign v1_x[0] = v1_pre.x;
    assign v1_y[0] = v1_pre.y;
    assign v1_z[0] = v1_pre.z;
    assign v1_v[0] = m1_valid_reg;
    assign v1_s[0] = {m1_y_reg, m1_nodir_reg};

    for (genvar i = 0; i < N; i++) begin : g_v1
        e2f_vec_cell #(.SHIFT(i), .SIDE_W(VW + 1)) u_v1 (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(v1_v[i]), .in_x(v1_x[i]), .in_y(v1_y[i]), .in_z(v1_z[i]),
            .in_side(v1_s[i]),
            .out_valid(v1_v[i+1]), .out_x(v1_x[i+1]), .out_y(v1_y[i+1]),
            .out_z(v1_z[i+1]), .out_side(v1_s[i+1])
        );
    end

    // remove the CORDIC gain from the magnitude
    logic signed [2*CW-1:0] p_mag;
    assign p_mag = v1_x[N] * e2f_pkg::GAIN_INV;

    logic                 m2_valid_reg, m2_nodir_reg;
    logic signed [VW-1:0] m2_xoz_reg, m2_y_reg;
    logic [AW-1:0]        m2_phi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (adv) begin
            m2_valid_reg <= v1_v[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_xoz_reg   <= $signed(p_mag[VW+29:30]);
            m2_y_reg     <= $signed(v1_s[N][VW:1]);
            m2_phi_reg   <= v1_z[N];
            m2_nodir_reg <= v1_s[N][0];
        end
    end

    // ---------------- vectoring of (y, |xz|): theta ----------------
    e2f_pkg::vec_pre_t v2_pre;
    assign v2_pre = e2f_pkg::vec_pre(m2_y_reg, m2_xoz_reg);

    logic signed [CW-1:0] v2_x [0:N], v2_y [0:N];
    logic [AW-1:0]        v2_z [0:N];
    logic                 v2_v [0:N];
    logic [AW:0]          v2_s [0:N];

    assign v2_x[0] = v2_pre.x;
    assign v2_y[0] = v2_pre.y;
    assign v2_z[0] = v2_pre.z;
    assign v2_v[0] = m2_valid_reg;
    assign v2_s[0] = {m2_phi_reg, m2_nodir_reg};

    for (genvar i = 0; i < N; i++) begin : g_v2
        e2f_vec_cell #(.SHIFT(i), .SIDE_W(AW + 1)) u_v2 (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(v2_v[i]), .in_x(v2_x[i]), .in_y(v2_y[i]), .in_z(v2_z[i]),
            .in_side(v2_s[i]),
            .out_valid(v2_v[i+1]), .out_x(v2_x[i+1]), .out_y(v2_y[i+1]),
            .out_z(v2_z[i+1]), .out_side(v2_s[i+1])
        );
    end

    // clamp theta into [0, pi], then halve it
    logic [AW-1:0] theta_c;
    always_comb begin
        priority if (v2_z[N] > 32'hC0000000) begin
            theta_c = '0;
        end else if (v2_z[N] > 32'h80000000) begin
            theta_c = 32'h80000000;
        end else begin
            theta_c = v2_z[N];
        end
    end

    // ---------------- rotation chains for sin(theta/2) and phi ----------------
    e2f_pkg::rot_pre_t r3_pre, r4_pre;
    assign r3_pre = e2f_pkg::rot_pre(theta_c >> 1);
    assign r4_pre = e2f_pkg::rot_pre(v2_s[N][AW:1]);

    logic signed [CW-1:0] r3_x [0:N], r3_y [0:N], r3_z [0:N];
    logic signed [CW-1:0] r4_x [0:N], r4_y [0:N], r4_z [0:N];
    logic                 r3_v [0:N], r4_v [0:N];
    logic [4:0]           r3_s [0:N];
    logic [3:0]           r4_s [0:N];

    assign r3_x[0] = r3_pre.x;
    assign r3_y[0] = r3_pre.y;
    assign r3_z[0] = r3_pre.z;
    assign r3_s[0] = {r3_pre.fix, v2_s[N][0]};
    assign r3_v[0] = v2_v[N];
    assign r4_x[0] = r4_pre.x;
    assign r4_y[0] = r4_pre.y;
    assign r4_z[0] = r4_pre.z;
    assign r4_s[0] = r4_pre.fix;
    assign r4_v[0] = v2_v[N];

    for (genvar i = 0; i < N; i++) begin : g_r34
        e2f_rot_cell #(.SHIFT(i), .SIDE_W(5)) u_r3 (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(r3_v[i]), .in_x(r3_x[i]), .in_y(r3_y[i]), .in_z(r3_z[i]),
            .in_side(r3_s[i]),
            .out_valid(r3_v[i+1]), .out_x(r3_x[i+1]), .out_y(r3_y[i+1]),
            .out_z(r3_z[i+1]), .out_side(r3_s[i+1])
        );
        e2f_rot_cell #(.SHIFT(i), .SIDE_W(4)) u_r4 (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .in_valid(r4_v[i]), .in_x(r4_x[i]), .in_y(r4_y[i]), .in_z(r4_z[i]),
            .in_side(r4_s[i]),
            .out_valid(r4_v[i+1]), .out_x(r4_x[i+1]), .out_y(r4_y[i+1]),
            .out_z(r4_z[i+1]), .out_side(r4_s[i+1])
        );
    end

    // ---------------- radius products ----------------
    e2f_pkg::sincos_t sc_half, sc_phi;
    logic signed [63:0] p_px, p_pz;

    assign sc_half = e2f_pkg::rot_post(e2f_pkg::rot_fix_t'(r3_s[N][4:1]), r3_x[N], r3_y[N]);
    assign sc_phi  = e2f_pkg::rot_post(e2f_pkg::rot_fix_t'(r4_s[N]), r4_x[N], r4_y[N]);
    assign p_px    = sc_phi.co * sc_half.si;
    assign p_pz    = sc_phi.si * sc_half.si;

    logic                 m3_valid_reg, m3_nodir_reg;
    logic signed [VW-1:0] m3_px_reg, m3_pz_reg;
    logic                 m4_valid_reg, m4_nodir_reg;
    logic signed [45:0]   m4_nx_reg, m4_nz_reg;
    logic                 m5_valid_reg, m5_nodir_reg, m5_sx_reg, m5_sz_reg;
    logic [e2f_pkg::NUM_W-1:0] m5_mx_reg, m5_mz_reg;

    logic signed [45:0]        two_f;
    logic [45:0]               abs_x, abs_z;
    logic [e2f_pkg::NUM_W-1:0] half_den;

    assign two_f    = 46'($signed({1'b0, focal_reg, 1'b0}));
    assign abs_x    = m4_nx_reg[45] ? 46'(-m4_nx_reg) : 46'(m4_nx_reg);
    assign abs_z    = m4_nz_reg[45] ? 46'(-m4_nz_reg) : 46'(m4_nz_reg);
    assign half_den = e2f_pkg::NUM_W'({span_eff, 13'd0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
            m5_valid_reg <= 1'b0;
        end else if (adv) begin
            m3_valid_reg <= r3_v[N] && r4_v[N];
            m4_valid_reg <= m3_valid_reg;
            m5_valid_reg <= m4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_px_reg    <= $signed(p_px[VW+29:30]);
            m3_pz_reg    <= $signed(p_pz[VW+29:30]);
            m3_nodir_reg <= r3_s[N][0];
            m4_nx_reg    <= 46'(m3_px_reg) * two_f;
            m4_nz_reg    <= 46'(m3_pz_reg) * two_f;
            m4_nodir_reg <= m3_nodir_reg;
            // add half the divisor for round to nearest, halves away from zero
            m5_mx_reg    <= abs_x[e2f_pkg::NUM_W-1:0] + half_den;
            m5_mz_reg    <= abs_z[e2f_pkg::NUM_W-1:0] + half_den;
            m5_sx_reg    <= m4_nx_reg[45];
            m5_sz_reg    <= m4_nz_reg[45];
            m5_nodir_reg <= m4_nodir_reg;
        end
    end

    // ---------------- divider chains ----------------
    // top dividend bits already sit below the divisor, so 30 quotient bits suffice
    logic [e2f_pkg::DEN_W-1:0]   dx_r [0:NQ], dz_r [0:NQ];
    logic [NQ-1:0]               dx_q [0:NQ], dz_q [0:NQ];
    logic [NQ-1:0]               dx_n [0:NQ], dz_n [0:NQ];
    logic                        dx_v [0:NQ], dz_v [0:NQ];
    logic [1:0]                  dx_s [0:NQ];
    logic [0:0]                  dz_s [0:NQ];

    assign dx_r[0] = e2f_pkg::DEN_W'(m5_mx_reg[e2f_pkg::NUM_W-1:NQ]);
    assign dz_r[0] = e2f_pkg::DEN_W'(m5_mz_reg[e2f_pkg::NUM_W-1:NQ]);
    assign dx_q[0] = '0;
    assign dz_q[0] = '0;
    assign dx_n[0] = m5_mx_reg[NQ-1:0];
    assign dz_n[0] = m5_mz_reg[NQ-1:0];
    assign dx_v[0] = m5_valid_reg;
    assign dz_v[0] = m5_valid_reg;
    assign dx_s[0] = {m5_sx_reg, m5_nodir_reg};
    assign dz_s[0] = m5_sz_reg;

    for (genvar i = 0; i < NQ; i++) begin : g_div
        e2f_div_cell #(.BIT(NQ - 1 - i), .SIDE_W(2)) u_dx (
            .aclk(aclk), .aresetn(aresetn), .en(adv), .den(den),
            .in_valid(dx_v[i]), .in_rem(dx_r[i]), .in_quo(dx_q[i]), .in_num(dx_n[i]),
            .in_side(dx_s[i]),
            .out_valid(dx_v[i+1]), .out_rem(dx_r[i+1]), .out_quo(dx_q[i+1]),
            .out_num(dx_n[i+1]), .out_side(dx_s[i+1])
        );
        e2f_div_cell #(.BIT(NQ - 1 - i), .SIDE_W(1)) u_dz (
            .aclk(aclk), .aresetn(aresetn), .en(adv), .den(den),
            .in_valid(dz_v[i]), .in_rem(dz_r[i]), .in_quo(dz_q[i]), .in_num(dz_n[i]),
            .in_side(dz_s[i]),
            .out_valid(dz_v[i+1]), .out_rem(dz_r[i+1]), .out_quo(dz_q[i+1]),
            .out_num(dz_n[i+1]), .out_side(dz_s[i+1])
        );
    end

    // ---------------- offset, saturate, output register ----------------
    logic signed [33:0] qx_abs, qz_abs, qx_s, qz_s;
    logic               out_nodir;
    logic               div_unused;

    assign qx_abs    = $signed({4'd0, dx_q[NQ]});
    assign qz_abs    = $signed({4'd0, dz_q[NQ]});
    assign qx_s      = dx_s[NQ][1] ? -qx_abs : qx_abs;
    assign qz_s      = dz_s[NQ][0] ? -qz_abs : qz_abs;
    assign out_nodir = dx_s[NQ][0];
    // final remainders and spent dividend bits carry no result
    assign div_unused = ^{dx_r[NQ], dz_r[NQ], dx_n[NQ], dz_n[NQ]};

    logic                        m_tvalid_reg;
    logic [e2f_pkg::OUT_W-1:0]   out_x_reg, out_y_reg, out_ym_reg;
    logic                        out_nodir_reg;

    assign adv = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dx_v[NQ] && dz_v[NQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_nodir_reg <= out_nodir;
            if (out_nodir) begin
                // no direction: park every coordinate at the center
                out_x_reg  <= e2f_pkg::HALF_Q16[e2f_pkg::OUT_W-1:0];
                out_y_reg  <= e2f_pkg::HALF_Q16[e2f_pkg::OUT_W-1:0];
                out_ym_reg <= e2f_pkg::HALF_Q16[e2f_pkg::OUT_W-1:0];
            end else begin
                out_x_reg  <= e2f_pkg::sat_out(e2f_pkg::HALF_Q16 + qx_s);
                out_y_reg  <= e2f_pkg::sat_out(e2f_pkg::HALF_Q16 - qz_s);
                out_ym_reg <= e2f_pkg::sat_out(e2f_pkg::HALF_Q16 + qz_s + 34'(div_unused & 1'b0));
            end
        end
    end

    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_ym_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_nodir_reg;

    // ---------------- assertions ----------------
    logic signed [e2f_pkg::OUT_W:0] y_pair_sum;
    assign y_pair_sum = (e2f_pkg::OUT_W+1)'($signed(out_y_reg)) +
                        (e2f_pkg::OUT_W+1)'($signed(out_ym_reg));

    // an accepted transaction lands in the first angle stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(s_tvalid && s_tready) |-> a1_valid_reg)
        else $error("accepted transaction lost at pipeline entry");

    // a result only appears when the divider chains delivered one
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(dx_v[NQ] && dz_v[NQ]))
        else $error("result valid without divider output");

    // parallel divider chains stay in lockstep
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_v[NQ] == dz_v[NQ])
        else $error("divider chains out of step");

    // unsaturated vertical pair mirrors about the center
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] &&
        ($signed(out_y_reg) != 18'sd131071) && ($signed(out_y_reg) != -18'sd131072) &&
        ($signed(out_ym_reg) != 18'sd131071) && ($signed(out_ym_reg) != -18'sd131072)
        |-> y_pair_sum == 19'sd65536)
        else $error("coord_y and coord_y_mirrored do not mirror about 0.5");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
endmodule
